[hdl/assert_macros.svh]
// Assertion macros shared by the sequencer RTL.
// Clocked on clock, disabled while reset is high; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/smcs_pkg.sv]
// Shared types, codes and helpers for the SMBus command sequencer.
// No dependencies; imported by every module of the block.
package smcs_pkg;

   localparam int MAX_COUNT_DEFAULT = 255;

   // Input item kinds
   localparam logic [1:0] KIND_BEGIN   = 2'd0;
   localparam logic [1:0] KIND_WRITE   = 2'd1;
   localparam logic [1:0] KIND_RECV    = 2'd2;
   localparam logic [1:0] KIND_TIMEOUT = 2'd3;

   // Transaction phases (code 3 behaves as idle)
   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_WRITE = 2'd1;
   localparam logic [1:0] PHASE_READ  = 2'd2;

   // Done status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_TIMEOUT = 1'b1;

   localparam logic [1:0] MAX_RESULTS = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_value;
      logic       skip_command;
      logic       skip_count;
      logic       hold_stop;
      logic [7:0] write_count;
      logic [7:0] read_count;
   } req_item_type;

   typedef struct packed {
      logic       word_valid;
      logic [7:0] word_data;
      logic       word_restart;
      logic       word_stop;
      logic       word_read;
      logic       data_valid;
      logic [7:0] data_out;
      logic       done_res;
      logic       status;
      logic [7:0] received_total;
      logic       last;
   } rsp_item_type;

   // Results of one item, slot 0 first
   typedef struct packed {
      rsp_item_type [2:0] res;
      logic [1:0]         cnt;
   } bundle_type;

   typedef struct packed {
      logic can_load;
      logic final_slot;
   } buf_status_type;

   // Build one result with unused fields forced to zero
   function automatic rsp_item_type mk_rsp(input logic wv, input logic [7:0] wd,
                                           input logic rs, input logic st,
                                           input logic rd, input logic dv,
                                           input logic [7:0] dout,
                                           input logic [7:0] total);
      rsp_item_type r;
      r.word_valid     = wv;
      r.word_data      = wv ? wd : 8'd0;
      r.word_restart   = wv & rs;
      r.word_stop      = wv & st;
      r.word_read      = wv & rd;
      r.data_valid     = dv;
      r.data_out       = dv ? dout : 8'd0;
      r.done_res       = 1'b0;
      r.status         = STATUS_OK;
      r.received_total = total;
      r.last           = 1'b0;
      return r;
   endfunction

endpackage

[hdl/smcs_step.sv]
// Transaction state registers and the single-pass step logic.
// Depends on smcs_pkg; turns one registered item into a result bundle.
module smcs_step
   import smcs_pkg::*;
#(
   parameter int MAX_COUNT = MAX_COUNT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_item_type item,
   output bundle_type   bundle
);

   localparam logic [7:0] MaxCount = 8'(MAX_COUNT);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] writes_left_ff, writes_left_in;
   logic [7:0] reads_left_ff, reads_left_in;
   logic       count_pending_ff, count_pending_in;
   logic       stop_held_ff, stop_held_in;
   logic       restart_pending_ff, restart_pending_in;
   logic [7:0] delivered_ff, delivered_in;

   // Compute results and next state for the item in the input register
   always_comb begin
      logic [7:0] wc;
      logic [7:0] rc;
      logic       do_start;
      logic       do_prefetch;
      logic       do_finish;
      logic       fin_status;
      logic [1:0] cnt;
      bundle_type b;

      phase_in           = phase_ff;
      writes_left_in     = writes_left_ff;
      reads_left_in      = reads_left_ff;
      count_pending_in   = count_pending_ff;
      stop_held_in       = stop_held_ff;
      restart_pending_in = restart_pending_ff;
      delivered_in       = delivered_ff;
      do_start    = 1'b0;
      do_prefetch = 1'b0;
      do_finish   = 1'b0;
      fin_status  = STATUS_OK;
      cnt         = 2'd0;
      b           = '0;
      wc = (item.write_count > MaxCount) ? MaxCount : item.write_count;
      rc = (item.read_count > MaxCount) ? MaxCount : item.read_count;

      unique case (item.kind)
         KIND_BEGIN: begin
            writes_left_in     = wc;
            reads_left_in      = rc;
            stop_held_in       = item.hold_stop;
            count_pending_in   = !item.skip_count && rc != 8'd0;
            restart_pending_in = 1'b1;
            delivered_in       = 8'd0;
            phase_in           = PHASE_IDLE;
            // command byte
            if (!item.skip_command) begin
               b.res[cnt] = mk_rsp(1'b1, item.byte_value, 1'b1,
                                   wc == 8'd0 && rc == 8'd0 && !item.hold_stop,
                                   1'b0, 1'b0, 8'd0, delivered_in);
               cnt = cnt + 2'd1;
               restart_pending_in = 1'b0;
            end
            // SMBus write count
            if (wc != 8'd0 && !item.skip_count) begin
               b.res[cnt] = mk_rsp(1'b1, wc, restart_pending_in, 1'b0,
                                   1'b0, 1'b0, 8'd0, delivered_in);
               cnt = cnt + 2'd1;
               restart_pending_in = 1'b0;
            end
            if (wc != 8'd0) begin
               phase_in = PHASE_WRITE;
            end else if (rc != 8'd0) begin
               do_start = 1'b1;
            end else begin
               do_finish = 1'b1;
            end
         end
         KIND_WRITE: begin
            if (phase_ff == PHASE_WRITE && writes_left_ff != 8'd0) begin
               b.res[cnt] = mk_rsp(1'b1, item.byte_value, restart_pending_ff,
                                   writes_left_ff == 8'd1 && reads_left_ff == 8'd0
                                   && !stop_held_ff,
                                   1'b0, 1'b0, 8'd0, delivered_in);
               cnt = cnt + 2'd1;
               restart_pending_in = 1'b0;
               writes_left_in     = writes_left_ff - 8'd1;
               if (writes_left_in == 8'd0) begin
                  if (reads_left_ff != 8'd0) begin
                     do_start = 1'b1;
                  end else begin
                     do_finish = 1'b1;
                  end
               end
            end
         end
         KIND_RECV: begin
            if (phase_ff == PHASE_READ && reads_left_ff != 8'd0) begin
               if (count_pending_ff) begin
                  // first byte is the SMBus count: clamp the read length
                  count_pending_in = 1'b0;
                  if (reads_left_ff > item.byte_value) begin
                     reads_left_in = item.byte_value;
                  end
               end else begin
                  delivered_in  = delivered_ff + 8'd1;
                  reads_left_in = reads_left_ff - 8'd1;
                  b.res[cnt] = mk_rsp(1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1,
                                      item.byte_value, delivered_in);
                  cnt = cnt + 2'd1;
               end
               if (reads_left_in == 8'd0) begin
                  do_finish = 1'b1;
               end else begin
                  do_prefetch = 1'b1;
               end
            end
         end
         KIND_TIMEOUT: begin
            if (phase_ff == PHASE_WRITE || phase_ff == PHASE_READ) begin
               do_finish  = 1'b1;
               fin_status = STATUS_TIMEOUT;
            end
         end
         default: begin
         end
      endcase

      // First read word of the read phase
      if (do_start) begin
         if (cnt != MAX_RESULTS) begin
            b.res[cnt] = mk_rsp(1'b1, 8'd0, 1'b1,
                                reads_left_in == 8'd1 && !count_pending_in
                                && !stop_held_in,
                                1'b1, 1'b0, 8'd0, delivered_in);
            cnt = cnt + 2'd1;
         end
         restart_pending_in = 1'b0;
         phase_in           = PHASE_READ;
         do_prefetch        = 1'b1;
      end

      // Keep one read queued ahead
      if (do_prefetch && reads_left_in > 8'd1 && cnt != MAX_RESULTS) begin
         b.res[cnt] = mk_rsp(1'b1, 8'd0, 1'b0,
                             !count_pending_in && reads_left_in == 8'd2
                             && !stop_held_in,
                             1'b1, 1'b0, 8'd0, delivered_in);
         cnt = cnt + 2'd1;
      end

      // Close the transaction, on a bare result if nothing else went out
      if (do_finish) begin
         if (cnt == 2'd0) begin
            b.res[0] = mk_rsp(1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,
                              delivered_in);
            cnt = 2'd1;
         end
         b.res[cnt - 2'd1].done_res = 1'b1;
         b.res[cnt - 2'd1].status   = fin_status;
         phase_in           = PHASE_IDLE;
         restart_pending_in = 1'b1;
      end

      if (cnt != 2'd0) begin
         b.res[cnt - 2'd1].last = 1'b1;
      end
      b.cnt  = cnt;
      bundle = b;
   end

   // Commit state when the item leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PHASE_IDLE;
         writes_left_ff     <= 8'd0;
         reads_left_ff      <= 8'd0;
         count_pending_ff   <= 1'b0;
         stop_held_ff       <= 1'b0;
         restart_pending_ff <= 1'b1;
         delivered_ff       <= 8'd0;
      end else if (advance) begin
         phase_ff           <= phase_in;
         writes_left_ff     <= writes_left_in;
         reads_left_ff      <= reads_left_in;
         count_pending_ff   <= count_pending_in;
         stop_held_ff       <= stop_held_in;
         restart_pending_ff <= restart_pending_in;
         delivered_ff       <= delivered_in;
      end
   end

endmodule

[hdl/smcs_rsp_buffer.sv]
// Result register: holds one bundle and hands its results out one a cycle while rsp_stall is low.
// Depends on smcs_pkg.
module smcs_rsp_buffer
   import smcs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load_en,
   input  bundle_type     load_bundle,
   input  logic           rsp_stall,
   output logic           rsp_valid,
   output rsp_item_type   rsp_item,
   output buf_status_type status
);

   bundle_type bundle_ff;
   logic [1:0] index_ff, index_in;
   logic [1:0] left_ff, left_in;
   logic       rsp_accept;

   assign rsp_valid  = left_ff != 2'd0;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign rsp_item   = bundle_ff.res[index_ff];

   // Free when empty or when the last result leaves this cycle
   assign status.can_load   = (left_ff == 2'd0) || (left_ff == 2'd1 && rsp_accept);
   assign status.final_slot = left_ff == 2'd1;

   // Advance the read slot, reload on a new bundle
   always_comb begin
      index_in = index_ff;
      left_in  = left_ff;
      if (load_en) begin
         index_in = 2'd0;
         left_in  = load_bundle.cnt;
      end else if (rsp_accept) begin
         index_in = index_ff + 2'd1;
         left_in  = left_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 2'd0;
         left_ff  <= 2'd0;
      end else begin
         index_ff <= index_in;
         left_ff  <= left_in;
      end
   end

   // Payload holds until the next bundle arrives
   always_ff @(posedge clock) begin
      if (load_en) begin
         bundle_ff <= load_bundle;
      end
   end

endmodule

[hdl/smbus_master_command_sequencer_core.sv]
// SMBus/I2C master command sequencer. A transaction is accepted into an input
// register and, in the cycle it leaves, the step logic produces all of its
// results (zero to three) into the result buffer, which delivers them one per
// cycle while rsp_stall is low. An item with no result does not load the
// result buffer. The single output port of the result buffer sets the
// sustained rate; a new transaction is accepted while earlier results are
// still being taken.
// Depends on smcs_pkg, smcs_step, smcs_rsp_buffer and assert_macros.svh.
`include "assert_macros.svh"

module smbus_master_command_sequencer_core
   import smcs_pkg::*;
#(
   parameter int MAX_COUNT = MAX_COUNT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_byte_value,
   input  logic       req_skip_command,
   input  logic       req_skip_count,
   input  logic       req_hold_stop,
   input  logic [7:0] req_write_count,
   input  logic [7:0] req_read_count,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_word_valid,
   output logic [7:0] rsp_word_data,
   output logic       rsp_word_restart,
   output logic       rsp_word_stop,
   output logic       rsp_word_read,
   output logic       rsp_data_valid,
   output logic [7:0] rsp_data_out,
   output logic       rsp_done_res,
   output logic       rsp_status,
   output logic [7:0] rsp_received_total,
   output logic       rsp_last
);

   req_item_type   item_ff;
   logic           item_valid_ff, item_valid_in;
   logic           req_accept;
   logic           advance;
   bundle_type     bundle;
   rsp_item_type   rsp_item;
   buf_status_type buf_status;

   assign advance    = item_valid_ff && buf_status.can_load;
   assign req_stall  = item_valid_ff && !buf_status.can_load;
   assign req_accept = req_valid && !req_stall;

   // Input register occupancy
   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_accept) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   // Capture the transaction payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.kind         <= req_kind;
         item_ff.byte_value   <= req_byte_value;
         item_ff.skip_command <= req_skip_command;
         item_ff.skip_count   <= req_skip_count;
         item_ff.hold_stop    <= req_hold_stop;
         item_ff.write_count  <= req_write_count;
         item_ff.read_count   <= req_read_count;
      end
   end

   smcs_step #(
      .MAX_COUNT (MAX_COUNT)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .bundle  (bundle)
   );

   smcs_rsp_buffer u_rsp_buffer (
      .clock       (clock),
      .reset       (reset),
      .load_en     (advance && bundle.cnt != 2'd0),
      .load_bundle (bundle),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .status      (buf_status)
   );

   assign rsp_word_valid     = rsp_item.word_valid;
   assign rsp_word_data      = rsp_item.word_data;
   assign rsp_word_restart   = rsp_item.word_restart;
   assign rsp_word_stop      = rsp_item.word_stop;
   assign rsp_word_read      = rsp_item.word_read;
   assign rsp_data_valid     = rsp_item.data_valid;
   assign rsp_data_out       = rsp_item.data_out;
   assign rsp_done_res       = rsp_item.done_res;
   assign rsp_status         = rsp_item.status;
   assign rsp_received_total = rsp_item.received_total;
   assign rsp_last           = rsp_item.last;

   // A pending item is never dropped before it is processed
   `ASSERT_NEXT(a_item_held, item_valid_ff && !advance, item_valid_ff, "item lost")
   // The final buffered result carries the last flag, and only it
   `ASSERT_IMPLY(a_last_slot, rsp_valid, rsp_last == buf_status.final_slot, "last misplaced")
   // Done is reported only on the final result of an item
   `ASSERT_IMPLY(a_done_last, rsp_valid && rsp_done_res, rsp_last, "done not last")
   // Stall on the request side only with an item waiting
   `ASSERT_IMPLY(a_stall_pending, req_stall, item_valid_ff, "stall without item")

endmodule
